### design/mtfc_pkg.sv
// shared types and constants for the move-to-front codec
package mtfc_pkg;

  localparam int ALPHABET_SIZE = 256;
  localparam int VAL_W = 8;
  localparam int RANK_W = $clog2(ALPHABET_SIZE);

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  typedef struct packed {
    logic [VAL_W-1:0] value_in;
    logic             last_in;
  } in_item_t;

  typedef struct packed {
    logic [VAL_W-1:0] value_out;
    logic             last_out;
  } out_item_t;

  // token that walks the cell row, one cell per cycle
  typedef struct packed {
    logic             valid;
    logic             mode;
    logic             found;
    logic [VAL_W-1:0] key;
    logic [VAL_W-1:0] carry;
    logic [VAL_W-1:0] hit_sym;
    logic [VAL_W-1:0] hit_rank;
  } wave_t;

endpackage

### design/mtfc_cell.sv
// one list position: holds the symbol at its rank and passes the walking token on
module mtfc_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [mtfc_pkg::RANK_W-1:0] idx,
  input  logic                      restore,
  input  logic                      front_we,
  input  logic [mtfc_pkg::VAL_W-1:0] front_sym,
  input  mtfc_pkg::wave_t           wave_in,
  output mtfc_pkg::wave_t           wave_out
);
  import mtfc_pkg::*;

  logic [VAL_W-1:0] sym;
  logic             hit;
  logic             active;
  wave_t            wave_next;

  assign active = wave_in.valid && !wave_in.found;

  always_comb begin
    if (wave_in.mode == DIR_DECODE) begin
      hit = (wave_in.key == VAL_W'(idx));
    end else begin
      hit = (wave_in.key == sym);
    end
  end

  // ahead of the hit every cell shifts down by one rank
  always_comb begin
    wave_next = wave_in;
    if (active) begin
      wave_next.carry = sym;
      if (hit) begin
        wave_next.found    = 1'b1;
        wave_next.hit_sym  = sym;
        wave_next.hit_rank = VAL_W'(idx);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restore) begin
      sym <= VAL_W'(idx);
    end else if (front_we) begin
      sym <= front_sym;
    end else if (active) begin
      sym <= wave_in.carry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_out <= '0;
    end else begin
      wave_out <= wave_next;
    end
  end

endmodule

### design/move_to_front_codec_top.sv
// move-to-front codec top level: control, configuration and the row of list cells
//
// Byte-wise move-to-front encoder/decoder over a 256-symbol list held in a row of
// cells, one cell per rank. Set direction (0 encode, 1 decode) through cfg_we and
// cfg_wdata while the block is idle. Each accepted transaction sends a token down
// the row one cell per clock; the cell that matches gives up its symbol and every
// cell ahead of it shifts down one rank on the way. The result is loaded into the
// output register once the token has walked through the full row, and the next
// transaction can be accepted in the cycle after that load, even if the result
// is not yet taken. One transaction is in flight at a time. A transaction with
// last_in set returns the list to identity order once its result is formed.
// The list is in identity order after reset; there is no clearing pass.
module move_to_front_codec_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  mtfc_pkg::in_item_t           in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output mtfc_pkg::out_item_t          out_data,
  input  logic                         cfg_we,
  input  logic                         cfg_wdata
);
  import mtfc_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0]       state;
  logic             direction;
  logic             cur_last;
  logic [VAL_W-1:0] hold_value;
  logic             hold_last;

  logic             accept;
  logic             out_of_range;
  logic             walk_done;
  logic             slot_free;
  logic             out_load;
  logic             restore;
  logic             front_we;
  logic [VAL_W-1:0] res_value;
  wave_t            head;
  wave_t            chain [ALPHABET_SIZE+1];
  wave_t            tail;

  assign in_ready     = (state == ST_IDLE);
  assign accept       = in_valid && in_ready;
  assign out_of_range = ({1'b0, in_data.value_in} >= (VAL_W+1)'(ALPHABET_SIZE));
  assign slot_free    = !out_valid || out_ready;

  assign tail      = chain[ALPHABET_SIZE];
  assign walk_done = (state == ST_WALK) && tail.valid;
  assign res_value = (tail.mode == DIR_DECODE) ? tail.hit_sym : tail.hit_rank;
  assign out_load  = slot_free && (walk_done || (state == ST_HOLD));

  // end of block wins over the front write
  assign restore  = (accept && out_of_range && in_data.last_in) || (walk_done && cur_last);
  assign front_we = walk_done && !cur_last;

  always_comb begin
    head       = '0;
    head.valid = accept && !out_of_range;
    head.mode  = direction;
    head.found = 1'b0;
    head.key   = in_data.value_in;
    head.carry = in_data.value_in;
  end

  assign chain[0] = head;

  for (genvar k = 0; k < ALPHABET_SIZE; k++) begin : g_cell
    if (k == 0) begin : g_front
      mtfc_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .idx       (RANK_W'(k)),
        .restore   (restore),
        .front_we  (front_we),
        .front_sym (tail.hit_sym),
        .wave_in   (chain[k]),
        .wave_out  (chain[k+1])
      );
    end else begin : g_rest
      mtfc_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .idx       (RANK_W'(k)),
        .restore   (restore),
        .front_we  (1'b0),
        .front_sym ('0),
        .wave_in   (chain[k]),
        .wave_out  (chain[k+1])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      direction <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        direction <= cfg_wdata;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            cur_last <= in_data.last_in;
            if (out_of_range) begin
              hold_value <= in_data.value_in;
              hold_last  <= in_data.last_in;
              state      <= ST_HOLD;
            end else begin
              state <= ST_WALK;
            end
          end
        end
        ST_WALK: begin
          if (walk_done) begin
            if (slot_free) begin
              out_data.value_out <= res_value;
              out_data.last_out  <= cur_last;
              state              <= ST_IDLE;
            end else begin
              hold_value <= res_value;
              hold_last  <= cur_last;
              state      <= ST_HOLD;
            end
          end
        end
        ST_HOLD: begin
          if (slot_free) begin
            out_data.value_out <= hold_value;
            out_data.last_out  <= hold_last;
            state              <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### bench/tb.sv
// testbench for the move-to-front codec: directed and random transactions checked against a list model
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mtfc_pkg::*;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      out_ready = 1'b0;
  logic      cfg_we = 1'b0;
  logic      cfg_wdata = DIR_ENCODE;
  in_item_t  in_data = '0;
  logic      in_ready;
  logic      out_valid;
  out_item_t out_data;

  move_to_front_codec_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // list model: symbol held at each rank and rank held by each symbol
  logic [VAL_W-1:0] sym_at_rank [ALPHABET_SIZE];
  logic [VAL_W-1:0] rank_of_sym [ALPHABET_SIZE];
  logic             mode_dir = DIR_ENCODE;

  in_item_t  send_queue[$];
  out_item_t coded_queue[$];
  out_item_t coded_want;
  int        queued_count = 0;
  int        taken_count = 0;
  int        mismatch_count = 0;
  logic      in_acc = 1'b0;
  logic      quiet = 1'b0;
  logic      wait_drain = 1'b0;
  int        in_gap = 0;
  int        out_stall = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic void list_identity();
    for (int k = 0; k < ALPHABET_SIZE; k++) begin
      sym_at_rank[k] = VAL_W'(k);
      rank_of_sym[k] = VAL_W'(k);
    end
  endfunction

  // code one transaction with the current list, then update the list
  function automatic out_item_t mtf_code(in_item_t it);
    out_item_t        res;
    int               r;
    logic [VAL_W-1:0] s;
    res.value_out = it.value_in;
    res.last_out = it.last_in;
    if (int'(it.value_in) < ALPHABET_SIZE) begin
      if (mode_dir == DIR_ENCODE) begin
        r = int'(rank_of_sym[it.value_in]);
        res.value_out = VAL_W'(r);
      end else begin
        r = int'(it.value_in);
        res.value_out = sym_at_rank[r];
      end
      s = sym_at_rank[r];
      for (int k = r; k > 0; k--) begin
        sym_at_rank[k] = sym_at_rank[k-1];
        rank_of_sym[sym_at_rank[k]] = VAL_W'(k);
      end
      sym_at_rank[0] = s;
      rank_of_sym[s] = '0;
    end
    if (it.last_in) list_identity();
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
  endtask

  // monitor and checker
  always @(posedge clk) begin
    if (rst) begin
      in_acc <= 1'b0;
    end else begin
      in_acc <= in_valid && in_ready;
      if (cfg_we) mode_dir = cfg_wdata;
      if (out_valid && out_ready) begin
        if (coded_queue.size() == 0) begin
          report_mismatch("transaction with nothing expected", 32'(out_data), 32'd0);
        end else begin
          coded_want = coded_queue.pop_front();
          if (out_data.value_out !== coded_want.value_out)
            report_mismatch("value_out", 32'(out_data.value_out),
                            32'(coded_want.value_out));
          if (out_data.last_out !== coded_want.last_out)
            report_mismatch("last_out", 32'(out_data.last_out),
                            32'(coded_want.last_out));
        end
      end
      if (in_valid && in_ready) begin
        coded_queue.push_back(mtf_code(in_data));
        taken_count++;
      end
    end
  end

  // input driver: random gaps, and now and then a wait until all results are back
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_acc) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (wait_drain) begin
        in_valid <= 1'b0;
        if (coded_queue.size() == 0) begin
          wait_drain <= 1'b0;
          in_gap <= $urandom_range(0, 5);
        end
      end else if (send_queue.size() > 0) begin
        case (quiet ? 15 : $urandom_range(0, 15))
          0, 1, 2: begin
            in_valid <= 1'b0;
            wait_drain <= !quiet;
          end
          3: begin
            in_valid <= 1'b0;
            in_gap <= quiet ? 0 : $urandom_range(0, 5);
          end
          default: begin
            in_valid <= 1'b1;
            in_data <= send_queue.pop_front();
          end
        endcase
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output stalls
  always @(negedge clk) begin
    if (out_stall > 0) begin
      out_stall <= out_stall - 1;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      out_stall <= $urandom_range(0, 5);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic queue_item(logic [VAL_W-1:0] v, logic l);
    in_item_t it;
    it.value_in = v;
    it.last_in = l;
    send_queue.push_back(it);
    queued_count++;
  endtask

  task automatic write_direction(logic d);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= d;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (taken_count != queued_count || coded_queue.size() != 0);
  endtask

  // blocks of random length; encoding favors a few symbols, decoding favors low ranks
  task automatic random_phase(int n, logic d);
    logic [VAL_W-1:0] fav [8];
    int               block_left;
    int               pick;
    logic [VAL_W-1:0] v;
    logic             l;
    for (int k = 0; k < 8; k++) fav[k] = VAL_W'($urandom_range(0, 255));
    block_left = $urandom_range(1, 40);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 9);
      if (d == DIR_ENCODE) begin
        v = (pick < 6) ? fav[$urandom_range(0, 7)] : VAL_W'($urandom_range(0, 255));
      end else if (pick < 6) begin
        v = VAL_W'($urandom_range(0, 7));
      end else if (pick < 8) begin
        v = VAL_W'($urandom_range(0, 31));
      end else begin
        v = VAL_W'($urandom_range(0, 255));
      end
      block_left--;
      l = (block_left == 0);
      if (l) begin
        block_left = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 60);
      end else if ($urandom_range(0, 49) == 0) begin
        l = 1'b1;  // stray end of block
      end
      queue_item(v, l);
    end
  endtask

  initial begin
    list_identity();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // encode: both ends of the alphabet, repeats, end of block, and a block left open
    write_direction(DIR_ENCODE);
    queue_item(8'd0, 1'b0);
    queue_item(8'd255, 1'b0);
    queue_item(8'd0, 1'b0);
    queue_item(8'd255, 1'b0);
    queue_item(8'd255, 1'b0);
    queue_item(8'd128, 1'b0);
    queue_item(8'd127, 1'b0);
    queue_item(8'd1, 1'b1);
    queue_item(8'd255, 1'b0);
    queue_item(8'd254, 1'b0);
    wait_idle();

    // decode continues the open block with the list carried over
    write_direction(DIR_DECODE);
    queue_item(8'd0, 1'b0);
    queue_item(8'd255, 1'b0);
    queue_item(8'd255, 1'b0);
    queue_item(8'd1, 1'b0);
    queue_item(8'd128, 1'b1);
    queue_item(8'd255, 1'b0);
    queue_item(8'd0, 1'b0);
    queue_item(8'd254, 1'b0);
    queue_item(8'd2, 1'b1);
    queue_item(8'd0, 1'b1);
    wait_idle();

    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 7) quiet = 1'b1;
      write_direction(ph < 2 ? logic'(ph) : logic'($urandom_range(0, 1)));
      random_phase(172, mode_dir);
      wait_idle();
    end

    repeat (300) @(posedge clk);
    if (coded_queue.size() != 0)
      report_mismatch("results still expected", 32'd0, 32'(coded_queue.size()));
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

### sim.f
design/mtfc_pkg.sv
design/mtfc_cell.sv
design/move_to_front_codec_top.sv
bench/tb.sv
